// ===== rtl/klv_nested_deframer_macros.svh =====
// Assertion macros for the KLV nested deframer.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef KLV_NESTED_DEFRAMER_MACROS_SVH
`define KLV_NESTED_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KND_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/knd_pkg.sv =====
// Shared types, codes and constants of the KLV nested deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package knd_pkg;

  // Deepest nesting level an item may have is MAX_DEPTH - 1.
  localparam int unsigned MAX_DEPTH = 4;
  localparam int unsigned DEPTH_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned KEY_BYTES = 16;

  // Result queue depth; one step may push two words.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int unsigned GROUP_COUNT = 3;
  localparam logic [127:0] GROUP_LABEL [GROUP_COUNT] = '{
    128'h060e2b34_02010101_02080200_00000000,
    128'h060e2b34_020b0101_0e010301_01000000,
    128'h060e2b34_02010101_0e010102_01010000
  };
  // Bit g is set when the children of group g are keyed by BER tags.
  localparam logic [GROUP_COUNT-1:0] GROUP_LOCAL = 3'b010;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_TRUNCATED     = 3'd0;
  localparam logic [2:0] ERR_LEN_SIZE      = 3'd1;
  localparam logic [2:0] ERR_CHILD_EXCEEDS = 3'd2;
  localparam logic [2:0] ERR_TAG_SIZE      = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP      = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [4:0]  key_size;
    logic [63:0] value_length;
    logic [1:0]  nesting;
    logic        opens_group;
    logic        group_is_local;
    logic [7:0]  value_byte;
    logic        last_of_value;
    logic [2:0]  error_code;
  } out_word_t;

  // Words produced by one parser step, packed to the front.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/knd_out_fifo.sv =====
// Result queue of the KLV nested deframer: takes up to two words per cycle.
// Depends on knd_pkg.
`default_nettype none

module knd_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire knd_pkg::push_t   push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output knd_pkg::out_word_t    out_data_o
);
  import knd_pkg::*;

  out_word_t              mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0]   count_q, count_d;
  logic                   pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room for a full two-word push, judged on the registered level.
  assign room_o      = (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + OUT_PTR_W'(pop);
    count_d  = count_q + OUT_CNT_W'(push_i.count) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + OUT_PTR_W'(1)] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/knd_parser.sv =====
// Per-byte KLV parse step: key, BER length, value and group nesting state.
// Depends on knd_pkg.
`default_nettype none

module knd_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire knd_pkg::in_word_t word_i,
  input  wire logic         top_ber_tags_i,
  output knd_pkg::push_t    push_o
);
  import knd_pkg::*;

  localparam logic [2:0] PH_KEY     = 3'd0;
  localparam logic [2:0] PH_KEYMORE = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_LENMORE = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [63:0]        key_hi_q, key_hi_d;
  logic [63:0]        key_lo_q, key_lo_d;
  logic [4:0]         kseen_q, kseen_d;
  logic [4:0]         kexp_q, kexp_d;
  logic [3:0]         lbl_q, lbl_d;
  logic [63:0]        lacc_q, lacc_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               disc_q, disc_d;
  logic [63:0]        rem_q [MAX_DEPTH];
  logic [63:0]        rem_d [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] loc_q, loc_d;

  logic [7:0]         b;
  logic [63:0]        rem_dec [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] rem_zero;
  logic [63:0]        rem_cur;
  logic               ber;
  logic [6:0]         cnt;
  logic [63:0]        len;
  logic [63:0]        lacc_dec;
  logic [3:0]         lbl_dec;
  logic [4:0]         kseen_inc;
  logic               hdr, err, complete, key_clear, put_en;
  logic [2:0]         code;
  logic [GROUP_COUNT-1:0] grp_hit;
  logic               match, match_loc;
  logic [DEPTH_W-1:0] child_d, casc_d;
  logic [63:0]        base_hi, base_lo;
  logic [4:0]         base_seen;
  out_word_t          prim, trunc;
  logic               prim_v, trunc_v;

  assign b = word_i.data_byte;

  // Group label match on the collected key; only full 16-byte keys qualify.
  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_hit[g] = ({key_hi_q, key_lo_q} == GROUP_LABEL[g]);
    end
    match     = (kseen_q == 5'(KEY_BYTES)) && (|grp_hit);
    match_loc = match && (|(grp_hit & GROUP_LOCAL));
  end

  always_comb begin
    phase_d  = phase_q;
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    kseen_d  = kseen_q;
    kexp_d   = kexp_q;
    lbl_d    = lbl_q;
    lacc_d   = lacc_q;
    depth_d  = depth_q;
    disc_d   = disc_q;
    rem_d    = rem_q;
    loc_d    = loc_q;

    hdr       = 1'b0;
    err       = 1'b0;
    complete  = 1'b0;
    key_clear = 1'b0;
    put_en    = 1'b0;
    code      = ERR_TRUNCATED;
    len       = '0;
    prim      = '0;
    prim_v    = 1'b0;
    trunc     = '0;
    trunc_v   = 1'b0;
    casc_d    = depth_q;
    cnt       = b[6:0];
    ber       = (depth_q == '0) ? top_ber_tags_i : loc_q[depth_q];
    lacc_dec  = (lacc_q != '0) ? lacc_q - 64'd1 : '0;
    lbl_dec   = (lbl_q != '0) ? lbl_q - 4'd1 : '0;
    kseen_inc = (kseen_q != 5'd31) ? kseen_q + 5'd1 : kseen_q;
    child_d   = depth_q + DEPTH_W'(1);

    // Every byte taken at depth d counts against all open groups 1..d.
    rem_zero = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      rem_dec[k] = rem_q[k];
      if (k != 0 && DEPTH_W'(k) <= depth_q && rem_q[k] != '0) begin
        rem_dec[k] = rem_q[k] - 64'd1;
      end
      rem_zero[k] = (k != 0) && (rem_dec[k] == '0);
    end
    rem_cur = rem_dec[depth_q];

    if (step_i && !disc_q) begin
      rem_d = rem_dec;

      case (phase_q)
        PH_KEY: begin
          key_clear = 1'b1;
          if (ber) begin
            if (b[7]) begin
              if (cnt == '0 || cnt > 7'(KEY_BYTES)) begin
                err  = 1'b1;
                code = ERR_TAG_SIZE;
              end else begin
                kexp_d  = cnt[4:0];
                phase_d = PH_KEYMORE;
              end
            end else begin
              put_en  = 1'b1;
              kexp_d  = 5'd1;
              phase_d = PH_LEN;
            end
          end else begin
            put_en  = 1'b1;
            kexp_d  = 5'(KEY_BYTES);
            phase_d = PH_KEYMORE;
          end
        end
        PH_KEYMORE: begin
          put_en = 1'b1;
          if (kseen_inc >= kexp_q) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b[7]) begin
            if (cnt == 7'd1 || cnt == 7'd2 || cnt == 7'd4 || cnt == 7'd8) begin
              lbl_d   = cnt[3:0];
              lacc_d  = '0;
              phase_d = PH_LENMORE;
            end else begin
              err  = 1'b1;
              code = ERR_LEN_SIZE;
            end
          end else begin
            len = {56'd0, b};
            hdr = 1'b1;
          end
        end
        PH_LENMORE: begin
          lacc_d = {lacc_q[55:0], b};
          lbl_d  = lbl_dec;
          if (lbl_dec == '0) begin
            len = {lacc_q[55:0], b};
            hdr = 1'b1;
          end
        end
        PH_VALUE: begin
          lacc_d              = lacc_dec;
          prim_v              = 1'b1;
          prim.kind           = KIND_VALUE;
          prim.value_byte     = b;
          prim.last_of_value  = (lacc_dec == '0);
          if (lacc_dec == '0) begin
            phase_d  = PH_KEY;
            complete = 1'b1;
          end
        end
        default: begin
          phase_d = PH_KEY;
        end
      endcase

      // Key byte collection, big-endian and left aligned in two halves.
      base_hi   = key_clear ? '0 : key_hi_q;
      base_lo   = key_clear ? '0 : key_lo_q;
      base_seen = key_clear ? '0 : kseen_q;
      key_hi_d  = base_hi;
      key_lo_d  = base_lo;
      kseen_d   = base_seen;
      if (put_en) begin
        for (int j = 0; j < 8; j++) begin
          if (base_seen == 5'(j)) begin
            key_hi_d[63-8*j -: 8] = base_hi[63-8*j -: 8] | b;
          end
          if (base_seen == 5'(j + 8)) begin
            key_lo_d[63-8*j -: 8] = base_lo[63-8*j -: 8] | b;
          end
        end
        if (base_seen != 5'd31) begin
          kseen_d = base_seen + 5'd1;
        end
      end

      if (hdr) begin
        if (depth_q != '0 && len > rem_cur) begin
          err  = 1'b1;
          code = ERR_CHILD_EXCEEDS;
        end else if (match && len != '0 && depth_q == DEPTH_W'(MAX_DEPTH - 1)) begin
          err  = 1'b1;
          code = ERR_TOO_DEEP;
        end else begin
          prim_v              = 1'b1;
          prim.kind           = KIND_HEADER;
          prim.key_high       = key_hi_q;
          prim.key_low        = key_lo_q;
          prim.key_size       = kseen_q;
          prim.value_length   = len;
          prim.nesting        = 2'(depth_q);
          prim.opens_group    = match;
          prim.group_is_local = match_loc;
          if (match && len != '0) begin
            depth_d        = child_d;
            rem_d[child_d] = len;
            loc_d[child_d] = match_loc;
            phase_d        = PH_KEY;
          end else if (len != '0) begin
            lacc_d  = len;
            phase_d = PH_VALUE;
          end else begin
            phase_d  = PH_KEY;
            complete = 1'b1;
          end
        end
      end else if (!err && (phase_d inside {PH_KEYMORE, PH_LEN, PH_LENMORE}) &&
                   depth_q != '0 && rem_cur == '0) begin
        // The enclosing group ran out in the middle of a header.
        err  = 1'b1;
        code = ERR_CHILD_EXCEEDS;
      end

      if (err) begin
        prim_v          = 1'b1;
        prim            = '0;
        prim.kind       = KIND_ERROR;
        prim.error_code = code;
        disc_d          = 1'b1;
      end else if (complete) begin
        // Close every group whose byte count has run out, innermost first.
        casc_d = depth_q;
        for (int i = 0; i < MAX_DEPTH - 1; i++) begin
          if (casc_d != '0 && rem_zero[casc_d]) begin
            casc_d = casc_d - DEPTH_W'(1);
          end
        end
        depth_d = casc_d;
      end
    end else begin
      base_hi   = key_hi_q;
      base_lo   = key_lo_q;
      base_seen = kseen_q;
      casc_d    = depth_q;
    end

    if (step_i && word_i.end_of_buffer) begin
      if (!disc_d && !(phase_d == PH_KEY && depth_d == '0)) begin
        trunc_v          = 1'b1;
        trunc.kind       = KIND_ERROR;
        trunc.error_code = ERR_TRUNCATED;
      end
      phase_d  = PH_KEY;
      key_hi_d = '0;
      key_lo_d = '0;
      kseen_d  = '0;
      kexp_d   = '0;
      lbl_d    = '0;
      lacc_d   = '0;
      depth_d  = '0;
      disc_d   = 1'b0;
    end

    push_o.count  = 2'(prim_v) + 2'(trunc_v);
    push_o.first  = prim_v ? prim : trunc;
    push_o.second = trunc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_KEY;
      key_hi_q <= '0;
      key_lo_q <= '0;
      kseen_q  <= '0;
      kexp_q   <= '0;
      lbl_q    <= '0;
      lacc_q   <= '0;
      depth_q  <= '0;
      disc_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      kseen_q  <= kseen_d;
      kexp_q   <= kexp_d;
      lbl_q    <= lbl_d;
      lacc_q   <= lacc_d;
      depth_q  <= depth_d;
      disc_q   <= disc_d;
    end
  end

  // Group bookkeeping is always written when a group opens, before any read.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    loc_q <= loc_d;
  end

endmodule

`default_nettype wire

// ===== rtl/klv_nested_deframer.sv =====
// Top level of the KLV nested deframer: input stage, parser and result queue.
// Depends on knd_pkg, knd_parser, knd_out_fifo and klv_nested_deframer_macros.svh.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid_i/in_stall_o    in_data_i  (in_word_t)
//   out       source     out_valid_o/out_stall_i  out_data_o (out_word_t)
//   cfg       sink       cfg_we_i                 cfg_wdata_i (top_ber_tags)
//
// One input word is taken every cycle unless the input stalls; each word yields zero,
// one or two result words. An accepted word waits in the input register until the
// queue has room; it is then parsed and its result words are written into the queue.
// The result queue holds four words; the input stalls while a word waits in the
// input register and the queue has fewer than two free entries.
// Reset is asynchronous and clears top_ber_tags and all parse state but the group bookkeeping.
`default_nettype none
`include "klv_nested_deframer_macros.svh"

module klv_nested_deframer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire knd_pkg::in_word_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output knd_pkg::out_word_t  out_data_o
);
  import knd_pkg::*;

  // Configuration: top-level items keyed by BER tags instead of 16-byte labels.
  logic     top_ber_q;

  // Input register. It can be refilled in the same cycle its word is parsed.
  logic     inq_valid_q, inq_valid_d;
  in_word_t inq_word_q;

  logic     room;
  logic     step;
  logic     in_accept;
  push_t    push;
  logic     second_is_trunc;

  assign step       = inq_valid_q && room;
  assign in_stall_o = inq_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign second_is_trunc = (push.second.kind == KIND_ERROR) &&
                           (push.second.error_code == ERR_TRUNCATED);

  always_comb begin
    inq_valid_d = inq_valid_q;
    if (in_accept) begin
      inq_valid_d = 1'b1;
    end else if (step) begin
      inq_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      top_ber_q   <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
      if (cfg_we_i) begin
        top_ber_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      inq_word_q <= in_data_i;
    end
  end

  // The parser advances once per consumed word and reports the words it makes.
  knd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .word_i         (inq_word_q),
    .top_ber_tags_i (top_ber_q),
    .push_o         (push)
  );

  knd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A word pushed by the parser must be on offer in the next cycle.
  `KND_ASSERT_NEXT(a_push_visible, step && push.count != 2'd0, out_valid_o, "pushed word lost")
  // Only an end-of-buffer truncation can follow another result of the same step.
  `KND_ASSERT_NOW(a_second_trunc, push.count == 2'd2, second_is_trunc, "bad second result")
  // An accepted word is held in the input register until it is parsed.
  `KND_ASSERT_NEXT(a_accept_held, in_accept, inq_valid_q, "accepted word dropped")

endmodule

`default_nettype wire

// ===== tb/klv_nested_deframer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of klv_nested_deframer: nested KLV buffers, noise and
// broken buffers stream through the block under random gaps and stalls.
// Depends on knd_pkg and the deframer RTL; every result word is checked.

module klv_nested_deframer_test;
  import knd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 50;

  typedef logic [7:0] byte_seq_t [$];

  // Where the parser stands inside the current item.
  typedef enum logic [2:0] {AT_KEY, AT_KEY_MORE, AT_LEN, AT_LEN_MORE, AT_VALUE} parse_at_t;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  // The three labels whose items are opened as sets; only the second one has
  // children keyed by BER tags.
  localparam logic [127:0] SET_LABEL [3] = '{
    128'h060e2b34_02010101_02080200_00000000,
    128'h060e2b34_020b0101_0e010301_01000000,
    128'h060e2b34_02010101_0e010102_01010000
  };
  localparam logic [2:0] SET_IS_LOCAL = 3'b010;

  // Opening words, sent with BER tags at top level. Bit 8 marks the last byte
  // of a buffer. In order: an empty item, a one-byte value of all ones, a
  // two-byte tag with a long-form zero length, an eight-byte length of all ones
  // cut short by the end of the buffer, a long-form tag without a count, a tag
  // count beyond sixteen, and a three-byte length size.
  localparam logic [8:0] OPENING_WORDS [25] = '{
    9'h000, 9'h000,
    9'h07f, 9'h001, 9'h0ff,
    9'h082, 9'h012, 9'h034, 9'h081, 9'h000,
    9'h001, 9'h088, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h1ff,
    9'h080, 9'h155,
    9'h191,
    9'h005, 9'h183
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  klv_nested_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Words waiting to be sent, and result words the predictor has worked out
  // but the block has not delivered yet.
  in_word_t  pending_words [$];
  out_word_t expected_results [$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;

  // Predictor state. The per-level tables are written when a set opens and
  // are never read before that, so they need no initial value.
  bit          ber_top    = 1'b0;
  parse_at_t   p_at       = AT_KEY;
  logic [63:0] p_key_hi   = '0;
  logic [63:0] p_key_lo   = '0;
  logic [4:0]  p_key_seen = '0;
  logic [4:0]  p_key_want = '0;
  logic [3:0]  p_len_left = '0;
  logic [63:0] p_len_acc  = '0;
  int unsigned p_depth    = 0;
  logic [63:0] p_remaining [MAX_DEPTH];
  bit          p_local     [MAX_DEPTH];
  bit          p_discard  = 1'b0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  function automatic out_word_t error_word(logic [2:0] code);
    out_word_t w;
    w = '0;
    w.kind = KIND_ERROR;
    w.error_code = code;
    return w;
  endfunction

  // Appends a word to the send queue.
  function automatic void queue_word(in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Appends a predicted result word behind the ones already expected.
  function automatic void expect_result(out_word_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Key bytes fill the two halves from the top down; bytes past sixteen are
  // counted but not stored.
  function automatic void take_key_byte(logic [7:0] b);
    if (p_key_seen < 8)
      p_key_hi[63 - 8 * p_key_seen -: 8] = b;
    else if (p_key_seen < 16)
      p_key_lo[127 - 8 * p_key_seen -: 8] = b;
    if (p_key_seen < 31)
      p_key_seen++;
  endfunction

  // Advances the predicted parser by one accepted word and queues the result
  // words that the word causes.
  task automatic predict_deframe(in_word_t w);
    logic [7:0]  b;
    logic [2:0]  code;
    logic [63:0] len;
    int unsigned d;
    int unsigned c;
    int          grp;
    bit          err;
    bit          hdr;
    bit          done;
    bit          ber;
    out_word_t   r;
    b = w.data_byte;
    if (!p_discard) begin
      d = p_depth;
      err = 1'b0;
      hdr = 1'b0;
      done = 1'b0;
      code = ERR_TRUNCATED;
      len = '0;
      // Every byte taken at depth d counts against all enclosing sets.
      for (int k = 1; k <= d; k++)
        if (p_remaining[k] != 0)
          p_remaining[k]--;

      case (p_at)
        AT_KEY: begin
          ber = (d == 0) ? ber_top : p_local[d];
          p_key_hi = '0;
          p_key_lo = '0;
          p_key_seen = '0;
          if (ber && b[7]) begin
            if (b[6:0] == 0 || b[6:0] > KEY_BYTES) begin
              err = 1'b1;
              code = ERR_TAG_SIZE;
            end else begin
              p_key_want = 5'(b[6:0]);
              p_at = AT_KEY_MORE;
            end
          end else begin
            take_key_byte(b);
            p_key_want = ber ? 5'd1 : 5'(KEY_BYTES);
            p_at = ber ? AT_LEN : AT_KEY_MORE;
          end
        end
        AT_KEY_MORE: begin
          take_key_byte(b);
          if (p_key_seen >= p_key_want)
            p_at = AT_LEN;
        end
        AT_LEN: begin
          if (b[7]) begin
            if (b[6:0] == 1 || b[6:0] == 2 || b[6:0] == 4 || b[6:0] == 8) begin
              p_len_left = b[3:0];
              p_len_acc = '0;
              p_at = AT_LEN_MORE;
            end else begin
              err = 1'b1;
              code = ERR_LEN_SIZE;
            end
          end else begin
            len = 64'(b);
            hdr = 1'b1;
          end
        end
        AT_LEN_MORE: begin
          p_len_acc = {p_len_acc[55:0], b};
          if (p_len_left != 0)
            p_len_left--;
          if (p_len_left == 0) begin
            len = p_len_acc;
            hdr = 1'b1;
          end
        end
        AT_VALUE: begin
          if (p_len_acc != 0)
            p_len_acc--;
          r = '0;
          r.kind = KIND_VALUE;
          r.value_byte = b;
          r.last_of_value = (p_len_acc == 0);
          expect_result(r);
          if (p_len_acc == 0) begin
            p_at = AT_KEY;
            done = 1'b1;
          end
        end
        default: p_at = AT_KEY;
      endcase

      if (hdr) begin
        // Set labels are recognized on full sixteen-byte keys only.
        grp = -1;
        if (p_key_seen == 16)
          for (int g = 0; g < 3; g++)
            if ({p_key_hi, p_key_lo} == SET_LABEL[g])
              grp = g;
        if (d >= 1 && len > p_remaining[d]) begin
          err = 1'b1;
          code = ERR_CHILD_EXCEEDS;
        end else if (grp >= 0 && len != 0 && d + 1 >= MAX_DEPTH) begin
          err = 1'b1;
          code = ERR_TOO_DEEP;
        end else begin
          r = '0;
          r.kind = KIND_HEADER;
          r.key_high = p_key_hi;
          r.key_low = p_key_lo;
          r.key_size = p_key_seen;
          r.value_length = len;
          r.nesting = 2'(d);
          r.opens_group = (grp >= 0);
          r.group_is_local = (grp >= 0) && SET_IS_LOCAL[grp];
          expect_result(r);
          if (grp >= 0 && len != 0) begin
            p_depth = d + 1;
            p_remaining[d + 1] = len;
            p_local[d + 1] = r.group_is_local;
            p_at = AT_KEY;
          end else if (len != 0) begin
            p_len_acc = len;
            p_at = AT_VALUE;
          end else begin
            p_at = AT_KEY;
            done = 1'b1;
          end
        end
      end else if (!err && (p_at == AT_KEY_MORE || p_at == AT_LEN || p_at == AT_LEN_MORE) &&
                   d >= 1 && p_remaining[d] == 0) begin
        // The enclosing set ran out in the middle of a header.
        err = 1'b1;
        code = ERR_CHILD_EXCEEDS;
      end

      if (err) begin
        expect_result(error_word(code));
        p_discard = 1'b1;
      end else if (done) begin
        // Close every set that has no bytes left, innermost first.
        c = p_depth;
        while (c > 0 && p_remaining[c] == 0)
          c--;
        p_depth = c;
      end
    end

    // The end of a buffer outside an item boundary is a truncation, unless an
    // error already cut the buffer. Either way the parser starts over.
    if (w.end_of_buffer) begin
      if (!p_discard && !(p_at == AT_KEY && p_depth == 0))
        expect_result(error_word(ERR_TRUNCATED));
      p_at = AT_KEY;
      p_key_hi = '0;
      p_key_lo = '0;
      p_key_seen = '0;
      p_key_want = '0;
      p_len_left = '0;
      p_len_acc = '0;
      p_depth = 0;
      p_discard = 1'b0;
    end
  endtask

  // Builds one well-formed item at the given nesting level, now and then with
  // a wrong length. Sets get children of their own kind of key; a set at the
  // deepest level with children provokes the nesting error.
  function automatic byte_seq_t make_item(bit ber_key, int level);
    byte_seq_t    s;
    byte_seq_t    body;
    byte_seq_t    child;
    logic [127:0] key;
    int           grp;
    int           n;
    int           width;
    grp = -1;
    if (level <= 3 && $urandom_range(0, 99) < (level == 0 ? 45 : 30))
      grp = $urandom_range(0, 2);

    if (grp < 0 && ber_key) begin
      if ($urandom_range(0, 9) < 7) begin
        s.insert(s.size(), 8'($urandom_range(0, 127)));
      end else begin
        n = $urandom_range(1, KEY_BYTES);
        s.insert(s.size(), 8'h80 | 8'(n));
        repeat (n) s.insert(s.size(), 8'($urandom));
      end
    end else begin
      if (grp >= 0) begin
        key = SET_LABEL[grp];
      end else if ($urandom_range(0, 4) == 0) begin
        // A near miss: a set label with one byte changed.
        key = SET_LABEL[$urandom_range(0, 2)];
        n = $urandom_range(0, 15);
        key[8 * n +: 8] = key[8 * n +: 8] ^ 8'($urandom_range(1, 255));
      end else begin
        key = {$urandom, $urandom, $urandom, $urandom};
      end
      // A set label under BER tags travels as a sixteen-byte long-form tag.
      if (ber_key)
        s.insert(s.size(), 8'h90);
      for (int i = 0; i < KEY_BYTES; i++)
        s.insert(s.size(), key[127 - 8 * i -: 8]);
    end

    if (grp >= 0) begin
      repeat ($urandom_range(0, level >= 2 ? 1 : 3)) begin
        child = make_item(SET_IS_LOCAL[grp], level + 1);
        foreach (child[i]) body.insert(body.size(), child[i]);
      end
    end else begin
      n = $urandom_range(0, 39);
      n = (n == 0) ? $urandom_range(256, 300) :
          (n < 5)  ? $urandom_range(20, 150)  : $urandom_range(0, 6);
      repeat (n) body.insert(body.size(), 8'($urandom));
    end

    // Now and then the stated length is wrong, so that a child overruns its
    // set or a set ends in the middle of a child header.
    n = body.size();
    if (level > 0 && $urandom_range(0, 29) == 0)
      n += $urandom_range(1, 3);
    else if (grp >= 0 && n > 0 && $urandom_range(0, 19) == 0)
      n = $urandom_range(0, n - 1);

    if (n < 128 && $urandom_range(0, 3) != 0) begin
      s.insert(s.size(), 8'(n));
    end else begin
      do width = 1 << $urandom_range(0, 3);
      while ((width == 1 && n > 255) || (width == 2 && n > 65535));
      s.insert(s.size(), 8'h80 | 8'(width));
      for (int i = width - 1; i >= 0; i--)
        s.insert(s.size(), 8'(n >> (8 * i)));
    end
    foreach (body[i]) s.insert(s.size(), body[i]);
    return s;
  endfunction

  // Sender: offers the oldest pending word in bursts of random length with
  // random gaps between them. A stalled word is held unchanged. Each accepted
  // word goes through the predictor at the edge that takes it.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    bit offer;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_deframe(in_data_i);
        void'(pending_words.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Long bursts give stretches without any idling.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid_i <= offer;
        if (offer)
          in_data_i <= pending_words[0];
      end
    end
  end

  // Receiver: switches among stall patterns at random times, and now
  // and then holds off entirely. The first time a large backlog is queued it
  // holds off for a long stretch, so that the result queue fills and the
  // block has to stall its input while the sender keeps offering.
  rx_mode_t rx_mode        = RX_FREE;
  int       rx_mode_left   = 0;
  int       rx_hold_left   = 0;
  int       rx_tick        = 0;
  bit       long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    bit stall_next;
    if (rst_ni) begin
      rx_tick++;
      if (!long_hold_done && pending_words.size() > 100) begin
        long_hold_done = 1'b1;
        rx_hold_left = 120;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        stall_next = 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(16, 250);
          if ($urandom_range(0, 19) == 0)
            rx_hold_left = $urandom_range(30, 90);
        end
        rx_mode_left--;
        case (rx_mode)
          RX_FREE:     stall_next = 1'b0;
          RX_RANDOM:   stall_next = ($urandom_range(0, 2) == 0);
          RX_PERIODIC: stall_next = (rx_tick % 5 < 2);
          default:     stall_next = ($urandom_range(0, 9) < 8);
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // Checker: every accepted result word is compared field by field with the
  // oldest expected word.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", out_data_o.kind, want.kind);
        check_field("key_high", out_data_o.key_high, want.key_high);
        check_field("key_low", out_data_o.key_low, want.key_low);
        check_field("key_size", out_data_o.key_size, want.key_size);
        check_field("value_length", out_data_o.value_length, want.value_length);
        check_field("nesting", out_data_o.nesting, want.nesting);
        check_field("opens_group", out_data_o.opens_group, want.opens_group);
        check_field("group_is_local", out_data_o.group_is_local, want.group_is_local);
        check_field("value_byte", out_data_o.value_byte, want.value_byte);
        check_field("last_of_value", out_data_o.last_of_value, want.last_of_value);
        check_field("error_code", out_data_o.error_code, want.error_code);
      end
      results_seen++;
    end
  end

  // Watchdog far beyond the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Four phases alternate the top-level key format, starting with BER tags
  // and ending with the reset format of sixteen-byte labels. Each phase queues
  // its buffers at once and then waits until the block has drained.
  initial begin
    byte_seq_t s;
    byte_seq_t item;
    int        queued;
    int        pick;
    int        keep;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      // The register is written only while the block is idle.
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= !p[0];
      ber_top = !p[0];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;

      if (p == 0)
        foreach (OPENING_WORDS[i])
          queue_word(in_word_t'({OPENING_WORDS[i][7:0], OPENING_WORDS[i][8]}));

      // Most buffers are well-formed runs of items; the rest are noise, cut
      // short, or have one byte overwritten.
      queued = 0;
      while (queued < (p == 0 ? 270 : 290)) begin
        s.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 24)) s.insert(s.size(), 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            item = make_item(!p[0], 0);
            foreach (item[i]) s.insert(s.size(), item[i]);
          end
          if (pick < 22) begin
            keep = $urandom_range(1, s.size());
            while (s.size() > keep)
              void'(s.pop_back());
          end else if (pick < 30) begin
            s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
          end
        end
        foreach (s[i])
          queue_word(in_word_t'({s[i], 1'(i == s.size() - 1)}));
        queued += s.size();
      end

      while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0)
        @(posedge clk_i);
      // A last word may cause no result while the block still works on it.
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end

    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/knd_pkg.sv
rtl/knd_out_fifo.sv
rtl/knd_parser.sv
rtl/klv_nested_deframer.sv
tb/klv_nested_deframer_test.sv
